@@ src/rbs_pkg.sv @@
// shared constants, types and helpers for the ray box slab intersection block
`default_nettype none

package rbs_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 24;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned NUM_AXES          = 3;
  localparam int unsigned NUM_LANES         = 2 * NUM_AXES;

  localparam logic [2:0] NORMAL_NONE  = 3'd0;
  localparam logic [2:0] NORMAL_NEG_X = 3'd1;
  localparam logic [2:0] NORMAL_POS_X = 3'd2;
  localparam logic [2:0] NORMAL_NEG_Y = 3'd3;
  localparam logic [2:0] NORMAL_POS_Y = 3'd4;
  localparam logic [2:0] NORMAL_NEG_Z = 3'd5;
  localparam logic [2:0] NORMAL_POS_Z = 3'd6;

  // per-axis flags riding alongside the quotients
  typedef struct packed {
    logic [NUM_AXES-1:0] par;    // delta is zero
    logic [NUM_AXES-1:0] pmiss;  // start outside slab, used only when parallel
    logic [NUM_AXES-1:0] dneg;   // delta is negative
  } rbs_side_t;

  // entry face normal: minus axis for positive delta, plus axis for negative
  function automatic logic [2:0] entry_code(input logic [1:0] axis, input logic dneg);
    logic [2:0] base;
    base = {axis, 1'b0};
    return dneg ? base + 3'd2 : base + 3'd1;
  endfunction

endpackage

`default_nettype wire

@@ src/rbs_if.sv @@
// item channels: segment and box in, hit result out
`default_nettype none

interface rbs_in_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface

interface rbs_out_if #(
  parameter int unsigned FRACTION_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRACTION_BITS:0] hit_fraction;
  logic [2:0]             normal_code;

  modport source (output valid, hit, hit_fraction, normal_code, input ready);
  modport sink   (input valid, hit, hit_fraction, normal_code, output ready);
endinterface

`default_nettype wire

@@ src/rbs_prep.sv @@
// front of the chain: slab differences, magnitudes, saturation and integer bit
`default_nettype none

module rbs_prep #(
  parameter int unsigned COORD_WIDTH   = rbs_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  wire                                              clk_i,
  input  wire                                              rst_ni,
  input  wire                                              en_i,
  input  wire                                              valid_i,
  input  wire  [rbs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]    start_i,
  input  wire  [rbs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]    end_i,
  input  wire  [rbs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]    lo_i,
  input  wire  [rbs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]    hi_i,
  output logic                                             valid_o,
  output rbs_pkg::rbs_side_t                               side_o,
  output logic [rbs_pkg::NUM_LANES-1:0]                    sat_o,
  output logic [rbs_pkg::NUM_LANES-1:0]                    neg_o,
  output logic [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   d_o,
  output logic [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   r_o,
  output logic [rbs_pkg::NUM_LANES-1:0][FRACTION_BITS+1:0] q_o
);
  import rbs_pkg::*;

  // first stage: signed differences, lane 2a is entry, 2a+1 is exit
  logic signed [COORD_WIDTH:0] num_d [NUM_LANES];
  logic signed [COORD_WIDTH:0] num_q [NUM_LANES];
  logic signed [COORD_WIDTH:0] del_d [NUM_AXES];
  logic signed [COORD_WIDTH:0] del_q [NUM_AXES];
  rbs_side_t                   side1_d, side1_q;
  logic                        valid1_q;

  always_comb begin
    logic signed [COORD_WIDTH:0] s, e, lo, hi, lo_s, hi_s;
    for (int a = 0; a < NUM_AXES; a++) begin
      s    = {start_i[a][COORD_WIDTH-1], start_i[a]};
      e    = {end_i[a][COORD_WIDTH-1], end_i[a]};
      lo   = {lo_i[a][COORD_WIDTH-1], lo_i[a]};
      hi   = {hi_i[a][COORD_WIDTH-1], hi_i[a]};
      lo_s = lo - s;
      hi_s = hi - s;
      del_d[a]         = e - s;
      side1_d.par[a]   = (e == s);
      side1_d.pmiss[a] = (s < lo) || (s > hi);
      side1_d.dneg[a]  = del_d[a][COORD_WIDTH];
      num_d[2*a]       = side1_d.dneg[a] ? hi_s : lo_s;
      num_d[2*a+1]     = side1_d.dneg[a] ? lo_s : hi_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      num_q   <= num_d;
      del_q   <= del_d;
      side1_q <= side1_d;
    end
  end

  // second stage: magnitudes (always below 2^COORD_WIDTH), saturation, integer bit
  logic [NUM_LANES-1:0]                    sat_d, neg_d;
  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   dm_d, r_d;
  logic [NUM_LANES-1:0][FRACTION_BITS+1:0] q_d;

  always_comb begin
    logic signed [COORD_WIDTH:0] nn, dd;
    logic [COORD_WIDTH-1:0]      nm, dm;
    logic                        ge;
    for (int l = 0; l < NUM_LANES; l++) begin
      nn       = num_q[l];
      dd       = del_q[l/2];
      nm       = nn[COORD_WIDTH] ? COORD_WIDTH'(-nn) : nn[COORD_WIDTH-1:0];
      dm       = dd[COORD_WIDTH] ? COORD_WIDTH'(-dd) : dd[COORD_WIDTH-1:0];
      ge       = (nm >= dm);
      sat_d[l] = ({1'b0, nm} >= {dm, 1'b0});
      neg_d[l] = nn[COORD_WIDTH] ^ dd[COORD_WIDTH];
      dm_d[l]  = dm;
      r_d[l]   = ge ? nm - dm : nm;
      q_d[l]   = {{(FRACTION_BITS+1){1'b0}}, ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid1_q) begin
      side_o <= side1_q;
      sat_o  <= sat_d;
      neg_o  <= neg_d;
      d_o    <= dm_d;
      r_o    <= r_d;
      q_o    <= q_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rbs_cell.sv @@
// one restoring division step for all six lanes, registered
`default_nettype none

module rbs_cell #(
  parameter int unsigned COORD_WIDTH   = rbs_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  wire                                              clk_i,
  input  wire                                              rst_ni,
  input  wire                                              en_i,
  input  wire                                              valid_i,
  input  rbs_pkg::rbs_side_t                               side_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0]                    sat_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0]                    neg_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   d_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   r_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0][FRACTION_BITS+1:0] q_i,
  output logic                                             valid_o,
  output rbs_pkg::rbs_side_t                               side_o,
  output logic [rbs_pkg::NUM_LANES-1:0]                    sat_o,
  output logic [rbs_pkg::NUM_LANES-1:0]                    neg_o,
  output logic [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   d_o,
  output logic [rbs_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]   r_o,
  output logic [rbs_pkg::NUM_LANES-1:0][FRACTION_BITS+1:0] q_o
);
  import rbs_pkg::*;

  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   r_d;
  logic [NUM_LANES-1:0][FRACTION_BITS+1:0] q_d;

  always_comb begin
    logic [COORD_WIDTH:0] r2, dx;
    logic                 ge;
    for (int l = 0; l < NUM_LANES; l++) begin
      r2     = {r_i[l], 1'b0};
      dx     = {1'b0, d_i[l]};
      ge     = (r2 >= dx);
      // a remainder below the divisor stays so and fits back in COORD_WIDTH
      r_d[l] = ge ? COORD_WIDTH'(r2 - dx) : COORD_WIDTH'(r2);
      q_d[l] = {q_i[l][FRACTION_BITS:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      side_o <= side_i;
      sat_o  <= sat_i;
      neg_o  <= neg_i;
      d_o    <= d_i;
      r_o    <= r_d;
      q_o    <= q_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rbs_merge.sv @@
// end of the chain: signed parameters, entry max, exit min, miss test, result register
`default_nettype none

module rbs_merge #(
  parameter int unsigned FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  wire                                              clk_i,
  input  wire                                              rst_ni,
  input  wire                                              en_i,
  input  wire                                              valid_i,
  input  rbs_pkg::rbs_side_t                               side_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0]                    sat_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0]                    neg_i,
  input  wire  [rbs_pkg::NUM_LANES-1:0][FRACTION_BITS+1:0] q_i,
  output logic                                             valid_o,
  output logic                                             hit_o,
  output logic [FRACTION_BITS:0]                           frac_o,
  output logic [2:0]                                       normal_o
);
  import rbs_pkg::*;

  localparam int unsigned TW = FRACTION_BITS + 3;
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRACTION_BITS;
  localparam logic signed [TW-1:0] TWO = TW'(1) << (FRACTION_BITS + 1);

  logic                   hit_d;
  logic [FRACTION_BITS:0] frac_d;
  logic [2:0]             normal_d;

  always_comb begin
    logic signed [TW-1:0] mag, te, tx, enter, exitv;
    logic [2:0]           normal;
    logic                 miss;
    enter  = '0;
    exitv  = ONE;
    normal = NORMAL_NONE;
    miss   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      mag = sat_i[2*a] ? TWO : {1'b0, q_i[2*a]};
      te  = neg_i[2*a] ? -mag : mag;
      mag = sat_i[2*a+1] ? TWO : {1'b0, q_i[2*a+1]};
      tx  = neg_i[2*a+1] ? -mag : mag;
      if (side_i.par[a]) begin
        if (side_i.pmiss[a]) miss = 1'b1;
      end else begin
        if (te > enter) begin
          enter  = te;
          normal = entry_code(2'(a), side_i.dneg[a]);
        end
        if (tx < exitv) exitv = tx;
      end
    end
    if ((enter > exitv) || (exitv < 0) || (enter > ONE)) miss = 1'b1;
    // entry never drops below zero, and a hit keeps it at or below one
    hit_d    = !miss;
    frac_d   = miss ? '0 : enter[FRACTION_BITS:0];
    normal_d = miss ? NORMAL_NONE : normal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      hit_o    <= hit_d;
      frac_o   <= frac_d;
      normal_o <= normal_d;
    end
  end

endmodule

`default_nettype wire

@@ src/ray_box_slab_intersection.sv @@
// top level: segment versus box slab test as a chain of division cells
//
//   port   dir  handshake     payload
//   in_i   in   valid/ready   start, end, box_min, box_max per axis
//   out_o  out  valid/ready   hit, hit_fraction, normal_code
//
// one item per cycle unless stalled; two prep stages, one
// division cell per fraction bit, one result register
// the whole chain advances together; it stalls only when the result register
// is full and out_o.ready is low, and in_i.ready follows that
// reset clears the valid bits of every stage
`default_nettype none

module ray_box_slab_intersection #(
  parameter int unsigned COORD_WIDTH   = rbs_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  wire clk_i,
  input  wire rst_ni,
  rbs_in_if.sink    in_i,
  rbs_out_if.source out_o
);
  import rbs_pkg::*;

  logic en;
  logic out_valid;

  logic                                    valid_c [FRACTION_BITS+1];
  rbs_side_t                               side_c  [FRACTION_BITS+1];
  logic [NUM_LANES-1:0]                    sat_c   [FRACTION_BITS+1];
  logic [NUM_LANES-1:0]                    neg_c   [FRACTION_BITS+1];
  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   d_c     [FRACTION_BITS+1];
  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   r_c     [FRACTION_BITS+1];
  logic [NUM_LANES-1:0][FRACTION_BITS+1:0] q_c     [FRACTION_BITS+1];

  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = out_valid;

  rbs_prep #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_i.valid),
    .start_i({in_i.start_z, in_i.start_y, in_i.start_x}),
    .end_i  ({in_i.end_z, in_i.end_y, in_i.end_x}),
    .lo_i   ({in_i.box_min_z, in_i.box_min_y, in_i.box_min_x}),
    .hi_i   ({in_i.box_max_z, in_i.box_max_y, in_i.box_max_x}),
    .valid_o(valid_c[0]),
    .side_o (side_c[0]),
    .sat_o  (sat_c[0]),
    .neg_o  (neg_c[0]),
    .d_o    (d_c[0]),
    .r_o    (r_c[0]),
    .q_o    (q_c[0])
  );

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    rbs_cell #(
      .COORD_WIDTH  (COORD_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_c[i]),
      .side_i (side_c[i]),
      .sat_i  (sat_c[i]),
      .neg_i  (neg_c[i]),
      .d_i    (d_c[i]),
      .r_i    (r_c[i]),
      .q_i    (q_c[i]),
      .valid_o(valid_c[i+1]),
      .side_o (side_c[i+1]),
      .sat_o  (sat_c[i+1]),
      .neg_o  (neg_c[i+1]),
      .d_o    (d_c[i+1]),
      .r_o    (r_c[i+1]),
      .q_o    (q_c[i+1])
    );
  end

  rbs_merge #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[FRACTION_BITS]),
    .side_i  (side_c[FRACTION_BITS]),
    .sat_i   (sat_c[FRACTION_BITS]),
    .neg_i   (neg_c[FRACTION_BITS]),
    .q_i     (q_c[FRACTION_BITS]),
    .valid_o (out_valid),
    .hit_o   (out_o.hit),
    .frac_o  (out_o.hit_fraction),
    .normal_o(out_o.normal_code)
  );

endmodule

`default_nettype wire
